// ===== sv/cpol_pkg.sv =====
// cpol_pkg: shared constants, types and elaboration-time functions for complex_to_polar
// holds the arctangent table, fixed-point format constants and the cordic gain function
// no dependencies
`default_nettype none

package cpol_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF      = 16;
    localparam int MAX_ITER              = 24;
    localparam int FRAC_BITS             = 16;
    localparam int ZW                    = 34;
    localparam int OUT_WIDTH             = 16;
    localparam int ATAN_WIDTH            = 32;
    localparam int KQ_WIDTH              = 32;

    // atan(2^-i), 2^31 = pi
    localparam logic [ATAN_WIDTH-1:0] ATAN_STEPS [MAX_ITER] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic last;
        logic zero;
    } cpol_tag_t;

    // reciprocal of the cordic gain in q32, floor(2^62 / floor(sqrt(prod(1 + 4^-i)) in q30))
    function automatic logic [KQ_WIDTH-1:0] inv_gain(input int n);
        logic [63:0] p;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] g;
        logic [64:0] rem;
        logic [63:0] quo;
        logic [63:0] num;
        p    = 64'd1 << 60;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = '0;
        quo  = '0;
        num  = 64'd1 << 62;
        for (int i = 0; i < MAX_ITER; i++)
        begin
            if (i < n)
            begin
                p = p + (p >> (2 * i));
            end
        end
        for (int k = 0; k < 32; k++)
        begin
            if (p >= res + bitv)
            begin
                p   = p - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        g = (res == 64'd0) ? 64'd1 : res;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, g})
            begin
                rem    = rem - {1'b0, g};
                quo[b] = 1'b1;
            end
        end
        return quo[KQ_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpol_prerot.sv =====
// cpol_prerot: input register stage, turns the sample by +-pi/2 so the real part is not negative
// depends on cpol_pkg
`default_nettype none

module cpol_prerot #(
    parameter int SW = cpol_pkg::SAMPLE_WIDTH_DEF,
    parameter int XW = cpol_pkg::SAMPLE_WIDTH_DEF + cpol_pkg::FRAC_BITS + 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [SW-1:0]         re,
    input  wire logic signed [SW-1:0]         im,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [XW-1:0]              x,
    output logic signed [XW-1:0]              y,
    output logic signed [cpol_pkg::ZW-1:0]    z,
    output cpol_pkg::cpol_tag_t               tag
);

    localparam int ZW = cpol_pkg::ZW;

    logic                     valid_reg;
    logic signed [XW-1:0]     x_reg, x_next;
    logic signed [XW-1:0]     y_reg, y_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    cpol_pkg::cpol_tag_t      tag_reg, tag_next;
    logic signed [XW-1:0]     re_ext, im_ext;

    assign re_ext = XW'(re) <<< cpol_pkg::FRAC_BITS;
    assign im_ext = XW'(im) <<< cpol_pkg::FRAC_BITS;

    always_comb
    begin
        tag_next.last = last;
        tag_next.zero = (re == '0) && (im == '0);
        if (re[SW-1])
        begin
            if (!im[SW-1])
            begin
                x_next = im_ext;
                y_next = -re_ext;
                z_next = ZW'(34'sh040000000);
            end
            else
            begin
                x_next = -im_ext;
                y_next = re_ext;
                z_next = -ZW'(34'sh040000000);
            end
        end
        else
        begin
            x_next = re_ext;
            y_next = im_ext;
            z_next = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign x         = x_reg;
    assign y         = y_reg;
    assign z         = z_reg;
    assign tag       = tag_reg;

endmodule

`default_nettype wire

// ===== sv/cpol_iter.sv =====
// cpol_iter: one registered cordic vectoring micro-rotation, index fixed at elaboration
// depends on cpol_pkg
`default_nettype none

module cpol_iter #(
    parameter int XW  = cpol_pkg::SAMPLE_WIDTH_DEF + cpol_pkg::FRAC_BITS + 3,
    parameter int IDX = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [XW-1:0]         x_in,
    input  wire logic signed [XW-1:0]         y_in,
    input  wire logic signed [cpol_pkg::ZW-1:0] z_in,
    input  wire cpol_pkg::cpol_tag_t          tag_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [XW-1:0]              x_out,
    output logic signed [XW-1:0]              y_out,
    output logic signed [cpol_pkg::ZW-1:0]    z_out,
    output cpol_pkg::cpol_tag_t               tag_out
);

    localparam int ZW = cpol_pkg::ZW;
    localparam logic signed [ZW-1:0] ANGLE =
        ZW'(signed'({1'b0, cpol_pkg::ATAN_STEPS[IDX]}));

    logic                     valid_reg;
    logic signed [XW-1:0]     x_reg, x_next;
    logic signed [XW-1:0]     y_reg, y_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    cpol_pkg::cpol_tag_t      tag_reg;
    logic signed [XW-1:0]     dx, dy;

    assign dx = y_in >>> IDX;
    assign dy = x_in >>> IDX;

    always_comb
    begin
        if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign tag_out   = tag_reg;

endmodule

`default_nettype wire

// ===== sv/cpol_scale.sv =====
// cpol_scale: gain removal and rounding, two register stages (split multiply, then sum and round)
// depends on cpol_pkg
`default_nettype none

module cpol_scale #(
    parameter int                         XW = cpol_pkg::SAMPLE_WIDTH_DEF + cpol_pkg::FRAC_BITS + 3,
    parameter logic [cpol_pkg::KQ_WIDTH-1:0] KQ = '0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [XW-1:0]         x,
    input  wire logic signed [cpol_pkg::ZW-1:0] z,
    input  wire cpol_pkg::cpol_tag_t          tag,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [cpol_pkg::OUT_WIDTH-1:0]    magnitude,
    output logic signed [cpol_pkg::OUT_WIDTH-1:0] phase,
    output logic                              last_out
);

    localparam int ZW  = cpol_pkg::ZW;
    localparam int OW  = cpol_pkg::OUT_WIDTH;
    localparam int KW  = cpol_pkg::KQ_WIDTH;
    localparam int FB  = cpol_pkg::FRAC_BITS;
    localparam int XE  = (XW > KW + 1) ? XW : KW + 1;
    localparam int HW  = XE - KW;
    localparam int PHW = HW + KW;
    localparam int UW  = PHW + 1;

    // stage a: partial products and phase
    logic                     valid_a_reg;
    logic                     ready_a;
    logic [XE-1:0]            xe;
    logic [2*KW-1:0]          prod_lo;
    logic [KW-1:0]            prod_lo_reg;
    logic [PHW-1:0]           prod_hi_reg, prod_hi_next;
    logic [ZW-1:0]            z_round;
    logic [OW-1:0]            phase_a_reg, phase_a_next;
    logic                     last_a_reg;

    // stage b: sum, round, saturate
    logic                     valid_b_reg;
    logic                     ready_b;
    logic [UW-1:0]            u_sum;
    logic [UW-1:0]            u_round;
    logic [OW-1:0]            mag_next;
    logic [OW-1:0]            mag_reg;
    logic [OW-1:0]            phase_b_reg;
    logic                     last_b_reg;

    assign xe           = x[XW-1] ? '0 : XE'(unsigned'(x));
    assign prod_lo      = (2*KW)'(xe[KW-1:0]) * (2*KW)'(KQ);
    assign prod_hi_next = PHW'(xe[XE-1:KW]) * PHW'(KQ);
    assign z_round      = unsigned'(z) + ZW'(1 << (FB - 1));
    assign phase_a_next = tag.zero ? '0 : z_round[FB+OW-1:FB];

    assign u_sum   = UW'(prod_hi_reg) + UW'(prod_lo_reg);
    assign u_round = u_sum + UW'(1 << (FB - 1));
    assign mag_next = (u_round[UW-1:FB+OW] != '0) ? '1 : u_round[FB+OW-1:FB];

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            prod_lo_reg <= prod_lo[2*KW-1:KW];
            prod_hi_reg <= prod_hi_next;
            phase_a_reg <= phase_a_next;
            last_a_reg  <= tag.last;
        end
        if (ready_b && valid_a_reg)
        begin
            mag_reg     <= mag_next;
            phase_b_reg <= phase_a_reg;
            last_b_reg  <= last_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign magnitude = mag_reg;
    assign phase     = signed'(phase_b_reg);
    assign last_out  = last_b_reg;

endmodule

`default_nettype wire

// ===== sv/complex_to_polar.sv =====
// complex_to_polar: pipelined cordic vectoring, complex sample in, magnitude and phase out
// stages: each accepted sample word passes through these register stages in order to the polar word
// (one pre-rotation stage, one stage per micro-rotation, two gain-removal stages)
// throughput: one word per cycle while polar_ready is high; each stage holds its word while the next one is full
// reset: rst_n clears the stage valid bits only, the pipeline comes up empty
// depends on cpol_pkg, cpol_prerot, cpol_iter, cpol_scale
`default_nettype none

module complex_to_polar #(
    parameter int CORDIC_ITERATIONS = cpol_pkg::CORDIC_ITERATIONS_DEF,
    parameter int SAMPLE_WIDTH      = cpol_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       real_part,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       imag_part,
    input  wire logic                                 last,
    output logic                                      polar_valid,
    input  wire logic                                 polar_ready,
    output logic [cpol_pkg::OUT_WIDTH-1:0]            magnitude,
    output logic signed [cpol_pkg::OUT_WIDTH-1:0]     phase,
    output logic                                      last_out
);

    localparam int N  = (CORDIC_ITERATIONS > cpol_pkg::MAX_ITER) ?
                        cpol_pkg::MAX_ITER : CORDIC_ITERATIONS;
    localparam int XW = SAMPLE_WIDTH + cpol_pkg::FRAC_BITS + 3;
    localparam int ZW = cpol_pkg::ZW;
    localparam logic [cpol_pkg::KQ_WIDTH-1:0] KQ = cpol_pkg::inv_gain(N);

    logic                     v_s   [N+1];
    logic                     r_s   [N+1];
    logic signed [XW-1:0]     x_s   [N+1];
    logic signed [XW-1:0]     y_s   [N+1];
    logic signed [ZW-1:0]     z_s   [N+1];
    cpol_pkg::cpol_tag_t      tag_s [N+1];

    cpol_prerot #(
        .SW (SAMPLE_WIDTH),
        .XW (XW)
    ) u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .re        (real_part),
        .im        (imag_part),
        .last      (last),
        .out_valid (v_s[0]),
        .out_ready (r_s[0]),
        .x         (x_s[0]),
        .y         (y_s[0]),
        .z         (z_s[0]),
        .tag       (tag_s[0])
    );

    for (genvar k = 0; k < N; k++)
    begin : g_iter
        cpol_iter #(
            .XW  (XW),
            .IDX (k)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_s[k]),
            .in_ready  (r_s[k]),
            .x_in      (x_s[k]),
            .y_in      (y_s[k]),
            .z_in      (z_s[k]),
            .tag_in    (tag_s[k]),
            .out_valid (v_s[k+1]),
            .out_ready (r_s[k+1]),
            .x_out     (x_s[k+1]),
            .y_out     (y_s[k+1]),
            .z_out     (z_s[k+1]),
            .tag_out   (tag_s[k+1])
        );
    end

    cpol_scale #(
        .XW (XW),
        .KQ (KQ)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_s[N]),
        .in_ready  (r_s[N]),
        .x         (x_s[N]),
        .z         (z_s[N]),
        .tag       (tag_s[N]),
        .out_valid (polar_valid),
        .out_ready (polar_ready),
        .magnitude (magnitude),
        .phase     (phase),
        .last_out  (last_out)
    );

    // y of the last stage is left unused, as no further rotation follows to test its sign
    logic unused_y;
    assign unused_y = ^y_s[N];

endmodule

`default_nettype wire
